>>> hw/rtl/brfo_pkg.sv
`timescale 1ns / 1ps
// Package for the byte ring FIFO: operation codes, FSM states, shared
// constants and the memory control struct. No dependencies.
package brfo_pkg;

    localparam int DEPTH_DEF = 256;   // default store depth
    localparam int SIZE_CAP  = 256;   // ring size never exceeds this
    localparam int CFG_W     = 9;     // ring_size register width
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0] RING_SIZE_RST = 9'd256;
    localparam logic [CFG_W-1:0] RING_SIZE_MIN = 9'd2;
    localparam int WRITE_MARGIN = 2;  // free slots needed for a plain write

    // register index as seen on paddr[2]
    localparam logic REG_RING_SIZE = 1'b0;

    typedef enum logic [2:0] {
        MODE_WRITE     = 3'd0,
        MODE_OVERWRITE = 3'd1,
        MODE_READ      = 3'd2,
        MODE_PEEK      = 3'd3,
        MODE_SKIP      = 3'd4,
        MODE_ADVANCE   = 3'd5,
        MODE_RESET     = 3'd6
    } t_mode;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

>>> hw/rtl/brfo_store.sv
`timescale 1ns / 1ps
// Byte store of the ring: single-port synchronous RAM with a registered read.
// Per-entry valid flops make never-written bytes read as zero. Uses brfo_pkg.
module brfo_store #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brfo_pkg::t_mem_ctl   i_ctl,
    input  logic [$clog2((DEPTH < brfo_pkg::SIZE_CAP) ? DEPTH : brfo_pkg::SIZE_CAP)-1:0] i_addr,
    input  logic [7:0]           i_wdata,
    output logic [7:0]           o_rdata
);
    localparam int LIM = (DEPTH < brfo_pkg::SIZE_CAP) ? DEPTH : brfo_pkg::SIZE_CAP;

    logic [7:0]     r_mem [LIM];
    logic [LIM-1:0] r_valid;
    logic [7:0]     r_rdata;
    logic           r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvalid <= r_valid[i_addr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'd0;

endmodule

>>> hw/rtl/brfo_ctrl.sv
`timescale 1ns / 1ps
// Ring control: pointers, per-operation decode, sequencing FSM and the
// result register. Drives brfo_store; uses brfo_pkg.
module brfo_ctrl #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF,
    localparam int LIM  = (DEPTH < brfo_pkg::SIZE_CAP) ? DEPTH : brfo_pkg::SIZE_CAP,
    localparam int PW   = $clog2(LIM),
    localparam int SW   = PW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SW-1:0]      i_size,
    input  logic               i_cfg_wr,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic [7:0]         i_data_in,
    input  logic [8:0]         i_count,
    // store
    output brfo_pkg::t_mem_ctl o_mem_ctl,
    output logic [PW-1:0]      o_mem_addr,
    output logic [7:0]         o_mem_wdata,
    input  logic [7:0]         i_mem_rdata,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic [7:0]         o_data_out,
    output logic [8:0]         o_moved,
    output logic [7:0]         o_fill_level,
    output logic [7:0]         o_free_level
);

    brfo_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr, r_wr_ptr, n_wr_ptr;
    logic          r_item_ok, n_item_ok;
    logic          r_item_rd, n_item_rd;
    logic [8:0]    r_item_moved, n_item_moved;

    logic          r_out_valid, n_out_valid;
    logic          r_ok, n_ok;
    logic [7:0]    r_data, n_data;
    logic [8:0]    r_moved, n_moved;
    logic [7:0]    r_fill, n_fill;
    logic [7:0]    r_free, n_free;

    logic [SW-1:0] diff, filled, freec;
    logic [8:0]    filled9, freec9, mv;
    logic [PW-1:0] wr_next;
    logic          accept, out_room;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [PW-1:0] n,
                                               input logic [SW-1:0] sz);
        logic [PW:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= sz) begin
            s = s - sz;
        end
        return s[PW-1:0];
    endfunction

    // occupancy from the current pointers; after an accept these already
    // hold the post-operation values when the result is built
    always_comb begin
        diff = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr};
        if (r_wr_ptr >= r_rd_ptr) begin
            filled = diff;
        end else begin
            filled = diff + i_size;
        end
        freec   = i_size - SW'(1) - filled;
        filled9 = 9'(filled);
        freec9  = 9'(freec);
    end

    assign o_stall  = (r_state != brfo_pkg::S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_room = !r_out_valid || !i_stall;
    assign wr_next  = wrap_add(r_wr_ptr, PW'(1), i_size);

    always_comb begin
        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_item_ok    = r_item_ok;
        n_item_rd    = r_item_rd;
        n_item_moved = r_item_moved;
        n_out_valid  = r_out_valid && i_stall;
        n_ok         = r_ok;
        n_data       = r_data;
        n_moved      = r_moved;
        n_fill       = r_fill;
        n_free       = r_free;
        o_mem_ctl    = '0;
        o_mem_addr   = r_wr_ptr;
        mv           = 9'd0;

        unique case (r_state)
            brfo_pkg::S_IDLE: begin
                if (accept) begin
                    n_item_ok    = 1'b0;
                    n_item_rd    = 1'b0;
                    n_item_moved = 9'd0;
                    n_state      = brfo_pkg::S_RESP;
                    unique case (brfo_pkg::t_mode'(i_mode))
                        brfo_pkg::MODE_WRITE: begin
                            if (freec >= SW'(brfo_pkg::WRITE_MARGIN)) begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_wr_ptr        = wr_next;
                                n_item_ok       = 1'b1;
                            end
                        end
                        brfo_pkg::MODE_OVERWRITE: begin
                            o_mem_ctl.wr_en = 1'b1;
                            n_wr_ptr        = wr_next;
                            // ring was full: drop the oldest byte
                            if (wr_next == r_rd_ptr) begin
                                n_rd_ptr = wrap_add(r_rd_ptr, PW'(1), i_size);
                            end
                            n_item_ok = 1'b1;
                        end
                        brfo_pkg::MODE_READ: begin
                            if (filled != '0) begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_mem_addr      = r_rd_ptr;
                                n_rd_ptr        = wrap_add(r_rd_ptr, PW'(1), i_size);
                                n_item_ok       = 1'b1;
                                n_item_rd       = 1'b1;
                            end
                        end
                        brfo_pkg::MODE_PEEK: begin
                            if (i_count < filled9) begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_mem_addr      = wrap_add(r_rd_ptr, PW'(i_count), i_size);
                                n_item_ok       = 1'b1;
                                n_item_rd       = 1'b1;
                            end
                        end
                        brfo_pkg::MODE_SKIP: begin
                            mv           = (i_count < filled9) ? i_count : filled9;
                            n_rd_ptr     = wrap_add(r_rd_ptr, PW'(mv), i_size);
                            n_item_moved = mv;
                            n_item_ok    = (mv != 9'd0);
                        end
                        brfo_pkg::MODE_ADVANCE: begin
                            mv           = (i_count < freec9) ? i_count : freec9;
                            n_wr_ptr     = wrap_add(r_wr_ptr, PW'(mv), i_size);
                            n_item_moved = mv;
                            n_item_ok    = (mv != 9'd0);
                        end
                        brfo_pkg::MODE_RESET: begin
                            n_rd_ptr  = '0;
                            n_wr_ptr  = '0;
                            n_item_ok = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            brfo_pkg::S_RESP: begin
                // store data is ready; load the result once the slot frees up
                if (out_room) begin
                    n_out_valid = 1'b1;
                    n_ok        = r_item_ok;
                    n_data      = r_item_rd ? i_mem_rdata : 8'd0;
                    n_moved     = r_item_moved;
                    n_fill      = 8'(filled);
                    n_free      = 8'(freec);
                    n_state     = brfo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brfo_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_rd_ptr = '0;
            n_wr_ptr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brfo_pkg::S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_ok    <= n_item_ok;
        r_item_rd    <= n_item_rd;
        r_item_moved <= n_item_moved;
        r_ok         <= n_ok;
        r_data       <= n_data;
        r_moved      <= n_moved;
        r_fill       <= n_fill;
        r_free       <= n_free;
    end

    assign o_mem_wdata  = i_data_in;
    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_data_out   = r_data;
    assign o_moved      = r_moved;
    assign o_fill_level = r_fill;
    assign o_free_level = r_free;

endmodule

>>> hw/rtl/byte_ring_fifo_with_overwrite_core.sv
`timescale 1ns / 1ps
// Byte ring FIFO with overwrite, top level. Holds the ring_size register
// and its clamping, and ties brfo_ctrl to brfo_store. Uses brfo_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one operation per transfer:
//   i_mode selects write, overwrite, read, peek, skip, advance write or
//   pointer reset; i_data_in is the byte to store, i_count the peek offset
//   or skip/advance length. Output channel (o_valid / i_stall) returns one
//   result per operation: o_ok, o_data_out, o_moved and the fill and free
//   levels after the operation.
//   A result is loaded into the output register from S_RESP, after its
//   operation transfers, once that register is free. No new operation is
//   taken until then; the store is a single-port RAM with a registered
//   read and each operation makes one access before the next is taken.
//   A stalled result holds; one further operation may transfer and then
//   waits until the output register is free.
//   Reset: pointers go to zero, ring_size to 256, and every store byte
//   reads as zero until written. No clearing pass is needed.
//   Writing ring_size through the APB port (byte address 0) zeroes both
//   pointers; write it only while the block is idle.
module byte_ring_fifo_with_overwrite_core #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brfo_pkg::PADDR_W-1:0] paddr,
    input  logic [brfo_pkg::PDATA_W-1:0] pwdata,
    output logic [brfo_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // operations
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_mode,
    input  logic [7:0]                  i_data_in,
    input  logic [8:0]                  i_count,
    // results
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_ok,
    output logic [7:0]                  o_data_out,
    output logic [8:0]                  o_moved,
    output logic [7:0]                  o_fill_level,
    output logic [7:0]                  o_free_level
);
    localparam int LIM = (DEPTH < brfo_pkg::SIZE_CAP) ? DEPTH : brfo_pkg::SIZE_CAP;
    localparam int PW  = $clog2(LIM);
    localparam int SW  = PW + 1;
    localparam logic [brfo_pkg::CFG_W-1:0] LIM_CFG = brfo_pkg::CFG_W'(LIM);

    logic [brfo_pkg::CFG_W-1:0] r_ring_size;
    logic [SW-1:0]              eff_size;
    logic                       cfg_wr;

    brfo_pkg::t_mem_ctl mem_ctl;
    logic [PW-1:0]      mem_addr;
    logic [7:0]         mem_wdata, mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == brfo_pkg::REG_RING_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= brfo_pkg::RING_SIZE_RST;
        end else if (cfg_wr) begin
            r_ring_size <= pwdata[brfo_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == brfo_pkg::REG_RING_SIZE) begin
            prdata = brfo_pkg::PDATA_W'(r_ring_size);
        end
    end

    always_comb begin
        if (r_ring_size < brfo_pkg::RING_SIZE_MIN) begin
            eff_size = SW'(brfo_pkg::RING_SIZE_MIN);
        end else if (r_ring_size > LIM_CFG) begin
            eff_size = SW'(LIM_CFG);
        end else begin
            eff_size = SW'(r_ring_size);
        end
    end

    brfo_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_size       (eff_size),
        .i_cfg_wr     (cfg_wr),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_data_in    (i_data_in),
        .i_count      (i_count),
        .o_mem_ctl    (mem_ctl),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .i_mem_rdata  (mem_rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ok         (o_ok),
        .o_data_out   (o_data_out),
        .o_moved      (o_moved),
        .o_fill_level (o_fill_level),
        .o_free_level (o_free_level)
    );

    brfo_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

>>> hw/rtl/brfo_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends only on the top-level ports.
module brfo_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_ok,
    input logic [7:0] o_data_out,
    input logic [8:0] o_moved,
    input logic [7:0] o_fill_level,
    input logic [7:0] o_free_level
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_out) && $stable(o_ok)
                               && $stable(o_fill_level))
        else $error("stalled result changed");

    // one operation in flight: a transfer closes the input side next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an operation is in flight");

    // refused or empty operations report no byte and no movement
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_data_out == 8'd0 && o_moved == 9'd0)
        else $error("refused operation reports data or movement");

    // fill plus free is size minus one, never above 255
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_fill_level} + {1'b0, o_free_level}) <= 9'd255)
        else $error("fill and free levels inconsistent");

endmodule

bind byte_ring_fifo_with_overwrite_core brfo_chk u_brfo_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_ok         (o_ok),
    .o_data_out   (o_data_out),
    .o_moved      (o_moved),
    .o_fill_level (o_fill_level),
    .o_free_level (o_free_level)
);

>>> tb/byte_ring_fifo_with_overwrite_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_with_overwrite_core: directed and random
// ring operations under several ring sizes and idle/stall mixes. Uses brfo_pkg.
module byte_ring_fifo_with_overwrite_core_tb;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    // ring_size is register 0, byte address 0
    localparam logic [brfo_pkg::PADDR_W-1:0] ADDR_RING_SIZE = '0;

    typedef struct packed {
        logic       ok;
        logic [7:0] data_out;
        logic [8:0] moved;
        logic [7:0] fill_level;
        logic [7:0] free_level;
    } t_fifo_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [brfo_pkg::PADDR_W-1:0] paddr = '0;
    logic [brfo_pkg::PDATA_W-1:0] pwdata = '0;
    logic [brfo_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [2:0]                   i_mode = 3'd0;
    logic [7:0]                   i_data_in = 8'd0;
    logic [8:0]                   i_count = 9'd0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic                         o_ok;
    logic [7:0]                   o_data_out;
    logic [8:0]                   o_moved;
    logic [7:0]                   o_fill_level;
    logic [7:0]                   o_free_level;

    byte_ring_fifo_with_overwrite_core #(.DEPTH(brfo_pkg::DEPTH_DEF)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .i_count     (i_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ok        (o_ok),
        .o_data_out  (o_data_out),
        .o_moved     (o_moved),
        .o_fill_level(o_fill_level),
        .o_free_level(o_free_level)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ring mirror
    logic [7:0]                 ring_bytes [brfo_pkg::DEPTH_DEF];
    int                         rd_idx;
    int                         wr_idx;
    logic [brfo_pkg::CFG_W-1:0] size_reg;

    t_fifo_result expected_results [$];
    t_fifo_result exp_r;
    int           error_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           quiet_cycles = 0;

    function automatic int ring_span();
        int sz;
        sz = int'(size_reg);
        if (sz < int'(brfo_pkg::RING_SIZE_MIN)) sz = int'(brfo_pkg::RING_SIZE_MIN);
        if (sz > brfo_pkg::DEPTH_DEF) sz = brfo_pkg::DEPTH_DEF;
        if (sz > brfo_pkg::SIZE_CAP) sz = brfo_pkg::SIZE_CAP;
        return sz;
    endfunction

    function automatic int fill_count(input int sz);
        return (wr_idx >= rd_idx) ? wr_idx - rd_idx : sz - (rd_idx - wr_idx);
    endfunction

    function automatic int wrap_idx(input int p, input int n, input int sz);
        int q;
        q = p + n;
        if (q >= sz) q -= sz;
        return q;
    endfunction

    function automatic t_fifo_result apply_fifo_op(input logic [2:0] mode,
                                                   input logic [7:0] din,
                                                   input logic [8:0] cnt);
        t_fifo_result r;
        int sz, fill, room, n;
        r = '0;
        sz = ring_span();
        fill = fill_count(sz);
        room = sz - 1 - fill;
        unique case (mode)
            brfo_pkg::MODE_WRITE: begin
                if (room >= brfo_pkg::WRITE_MARGIN) begin
                    ring_bytes[wr_idx] = din;
                    wr_idx = wrap_idx(wr_idx, 1, sz);
                    r.ok = 1'b1;
                end
            end
            brfo_pkg::MODE_OVERWRITE: begin
                ring_bytes[wr_idx] = din;
                wr_idx = wrap_idx(wr_idx, 1, sz);
                // full ring: oldest byte is dropped
                if (wr_idx == rd_idx) rd_idx = wrap_idx(rd_idx, 1, sz);
                r.ok = 1'b1;
            end
            brfo_pkg::MODE_READ: begin
                if (fill != 0) begin
                    r.data_out = ring_bytes[rd_idx];
                    rd_idx = wrap_idx(rd_idx, 1, sz);
                    r.ok = 1'b1;
                end
            end
            brfo_pkg::MODE_PEEK: begin
                if (int'(cnt) < fill) begin
                    r.data_out = ring_bytes[wrap_idx(rd_idx, int'(cnt), sz)];
                    r.ok = 1'b1;
                end
            end
            brfo_pkg::MODE_SKIP: begin
                n = (int'(cnt) < fill) ? int'(cnt) : fill;
                rd_idx = wrap_idx(rd_idx, n, sz);
                r.moved = n[8:0];
                r.ok = (n != 0);
            end
            brfo_pkg::MODE_ADVANCE: begin
                n = (int'(cnt) < room) ? int'(cnt) : room;
                wr_idx = wrap_idx(wr_idx, n, sz);
                r.moved = n[8:0];
                r.ok = (n != 0);
            end
            brfo_pkg::MODE_RESET: begin
                rd_idx = 0;
                wr_idx = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        fill = fill_count(sz);
        room = sz - 1 - fill;
        r.fill_level = fill[7:0];
        r.free_level = room[7:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: result transfer with nothing expected, expected none actual %0h",
                         $time, {o_ok, o_data_out, o_moved, o_fill_level, o_free_level});
            end else begin
                exp_r = expected_results.pop_front();
                check_field("ok", 9'(exp_r.ok), 9'(o_ok));
                check_field("data_out", 9'(exp_r.data_out), 9'(o_data_out));
                check_field("moved", exp_r.moved, o_moved);
                check_field("fill_level", 9'(exp_r.fill_level), 9'(o_fill_level));
                check_field("free_level", 9'(exp_r.free_level), 9'(o_free_level));
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_op(input logic [2:0] mode, input logic [7:0] din,
                           input logic [8:0] cnt);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_data_in <= din;
        i_count   <= cnt;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(apply_fifo_op(mode, din, cnt));
    endtask

    // drop valid and wait until every result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ring_size(input int value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RING_SIZE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = value[brfo_pkg::CFG_W-1:0];
        rd_idx = 0;
        wr_idx = 0;
    endtask

    task automatic random_ops(input int n);
        int pick;
        logic [2:0] mode;
        logic [8:0] cnt;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 28)      mode = brfo_pkg::MODE_WRITE;
            else if (pick < 43) mode = brfo_pkg::MODE_OVERWRITE;
            else if (pick < 63) mode = brfo_pkg::MODE_READ;
            else if (pick < 73) mode = brfo_pkg::MODE_PEEK;
            else if (pick < 81) mode = brfo_pkg::MODE_SKIP;
            else if (pick < 88) mode = brfo_pkg::MODE_ADVANCE;
            else if (pick < 91) mode = brfo_pkg::MODE_RESET;
            else if (pick < 92) mode = MODE_UNUSED;
            else                mode = brfo_pkg::MODE_WRITE;
            if ($urandom_range(4) == 0) cnt = 9'($urandom_range(511));
            else                        cnt = 9'($urandom_range(ring_span() + 1));
            send_op(mode, 8'($urandom_range(255)), cnt);
        end
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_ring_size(256);
        send_op(brfo_pkg::MODE_READ, 8'h00, 9'd0);        // empty read
        send_op(brfo_pkg::MODE_PEEK, 8'h00, 9'd0);
        send_op(brfo_pkg::MODE_SKIP, 8'h00, 9'd5);
        send_op(brfo_pkg::MODE_WRITE, 8'h00, 9'd0);
        send_op(brfo_pkg::MODE_WRITE, 8'hFF, 9'd0);
        send_op(brfo_pkg::MODE_WRITE, 8'hA5, 9'd0);
        send_op(brfo_pkg::MODE_PEEK, 8'h00, 9'd2);
        send_op(brfo_pkg::MODE_PEEK, 8'h00, 9'd3);        // offset == fill
        send_op(brfo_pkg::MODE_READ, 8'h00, 9'd0);
        send_op(brfo_pkg::MODE_SKIP, 8'h00, 9'd256);      // clamps to fill
        send_op(brfo_pkg::MODE_ADVANCE, 8'h00, 9'd0);
        send_op(brfo_pkg::MODE_ADVANCE, 8'h00, 9'd256);   // clamps to free, ring full
        send_op(brfo_pkg::MODE_WRITE, 8'h77, 9'd0);       // refused
        send_op(brfo_pkg::MODE_OVERWRITE, 8'h5A, 9'd0);   // drops oldest
        send_op(brfo_pkg::MODE_READ, 8'h00, 9'd0);
        send_op(brfo_pkg::MODE_RESET, 8'h00, 9'd0);
        send_op(MODE_UNUSED, 8'hFF, 9'd511);
        set_ring_size(2);
        send_op(brfo_pkg::MODE_WRITE, 8'h11, 9'd0);       // never enough margin
        send_op(brfo_pkg::MODE_OVERWRITE, 8'h11, 9'd0);
        send_op(brfo_pkg::MODE_OVERWRITE, 8'h22, 9'd0);
        send_op(brfo_pkg::MODE_READ, 8'h00, 9'd0);
        set_ring_size(0);                                 // clamps up to 2
        send_op(brfo_pkg::MODE_OVERWRITE, 8'h33, 9'd0);
        send_op(brfo_pkg::MODE_PEEK, 8'h00, 9'd0);
        set_ring_size(511);                               // clamps down to 256
        send_op(brfo_pkg::MODE_ADVANCE, 8'h00, 9'd511);
        send_op(brfo_pkg::MODE_WRITE, 8'h44, 9'd0);
    endtask

    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_ring_size(256);
        random_ops(120);
        set_ring_size(3);
        random_ops(120);
        set_ring_size(17);
        random_ops(120);
    endtask

    task automatic test_sender_idle();
        tx_idle_pct = 68;
        rx_stall_pct = 0;
        set_ring_size(2);
        random_ops(120);
        set_ring_size(5);
        random_ops(120);
        set_ring_size(255);
        random_ops(120);
    endtask

    task automatic test_receiver_stall();
        tx_idle_pct = 0;
        rx_stall_pct = 68;
        set_ring_size(4);
        random_ops(120);
        set_ring_size(1);
        random_ops(120);
        set_ring_size(300);
        random_ops(120);
    endtask

    task automatic test_both_idle();
        tx_idle_pct = 23;
        rx_stall_pct = 23;
        set_ring_size(100);
        random_ops(100);
        set_ring_size(256);
        random_ops(100);
        set_ring_size(129);
        random_ops(100);
    endtask

    task automatic test_pause_until_empty();
        tx_idle_pct = 0;
        rx_stall_pct = 68;
        set_ring_size(8);
        random_ops(20);
        drain_results();
        random_ops(20);
    endtask

    initial begin
        for (int i = 0; i < brfo_pkg::DEPTH_DEF; i++) ring_bytes[i] = 8'd0;
        rd_idx = 0;
        wr_idx = 0;
        size_reg = brfo_pkg::RING_SIZE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_pause_until_empty();

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        drain_results();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
